// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the record ranker.
// Needs nothing else; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/tmrr_pkg.sv =====
// Shared types, constants and rank compare for the record ranker.
// Used by tmrr_ctrl, tmrr_datapath and top_m_record_ranker; no dependencies.
`timescale 1ns / 1ps

package tmrr_pkg;

    localparam int TAG_W   = 16;
    localparam int SCORE_W = 10;
    localparam int DATE_W  = 21;   // year:12 | month:4 | day:5
    localparam int TENTH_W = 14;
    localparam int TOP_W   = 7;

    localparam logic [TOP_W-1:0] RESULT_LIMIT = 7'd64;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] written;
        logic [SCORE_W-1:0] interview;
        logic [DATE_W-1:0]  date;
    } rec_t;

    // store write source
    typedef enum logic [1:0] {
        WR_NONE    = 2'd0,
        WR_SHIFT   = 2'd1,   // read entry moves one place down
        WR_NEW_UP  = 2'd2,   // new request lands one below the read entry
        WR_NEW_TOP = 2'd3    // new request lands at the head
    } wr_op_t;

    typedef struct packed {
        logic   load_rec;
        logic   set_ovf;
        logic   idx_init;
        logic   idx_dec;
        logic   rd_emit;
        wr_op_t wr_op;
        logic   count_inc;
        logic   clear;
        logic   emit_init;
        logic   emit_inc;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic above;
        logic idx_zero;
        logic last;
        logic n_zero;
        logic emit_last;
    } stat_t;

    // 8*written + 2*interview, exact
    function automatic logic [TENTH_W-1:0] weighted(input rec_t r);
        return {1'b0, r.written, 3'b000} + {3'b000, r.interview, 1'b0};
    endfunction

    // a strictly ahead of b
    function automatic logic ranks_above(input rec_t a, input rec_t b);
        logic [TENTH_W-1:0] sa;
        logic [TENTH_W-1:0] sb;
        sa = weighted(a);
        sb = weighted(b);
        if (sa != sb)
            return sa > sb;
        if (a.written != b.written)
            return a.written > b.written;
        return a.date > b.date;
    endfunction

endpackage

// ===== hw/rtl/top_m_record_ranker.sv =====
// Top level of the record ranker: ports, controller and datapath.
// Depends on tmrr_pkg, tmrr_ctrl, tmrr_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Record ranker: keeps incoming records sorted by weighted score
// (8*written + 2*interview), then written score, then later birth date;
// equal records keep arrival order. On a request with last_record set,
// that record is stored if there is room, then the best top_count records
// are sent out best first, and the store empties.
// Input channel: in_valid/in_ready carry one record request. in_ready is
// high only while the sequencer is idle.
// Insertion scans the store from its tail with one registered memory read
// per entry (read, then compare).
// Output channel: out_valid/out_ready; each result takes a store read,
// an output register load and a handshake. A stalled receiver simply
// holds the sequencer in the wait state.
// Records arriving with the store full are dropped and records_dropped is
// flagged on every result of that set. The user must write top_count
// through cfg_we/cfg_wdata only while the block is idle, which the block
// itself leaves unchecked; values above 64 act as 64.
// Reset clears the count, drop flag, top_count and sequencer; store
// contents are left as they are and are never read before being written.

module top_m_record_ranker #(
    parameter int MAX_RECORDS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] record_tag,
    input  logic [9:0]  written_score,
    input  logic [9:0]  panel_score,
    input  logic [11:0] year_born,
    input  logic [3:0]  month_born,
    input  logic [4:0]  birth_day,
    input  logic        last_record,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_tag,
    output logic [13:0] score_tenths,
    output logic        records_dropped,
    output logic        last_result
);

    tmrr_pkg::cmd_t  cmd;
    tmrr_pkg::stat_t stat;
    tmrr_pkg::rec_t  in_rec;

    // date packs so a plain compare orders year, month, day
    assign in_rec.tag       = record_tag;
    assign in_rec.written   = written_score;
    assign in_rec.interview = panel_score;
    assign in_rec.date      = {year_born, month_born, birth_day};

    tmrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tmrr_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_rec          (in_rec),
        .in_last         (last_record),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .out_tag         (out_tag),
        .score_tenths    (score_tenths),
        .records_dropped (records_dropped),
        .last_result     (last_result)
    );

    // emission and intake never overlap
    `ASSERT_NEVER(a_no_in_during_out, clk, rst_n, out_valid && in_ready)
    // final result taken: store cleared, back to idle
    `ASSERT_PROP(a_idle_after_last, clk, rst_n, out_valid && out_ready && last_result |=> in_ready)
    // each further result needs a fresh store read first
    `ASSERT_PROP(a_gap_between_results, clk, rst_n, out_valid && out_ready && !last_result |=> !out_valid)

endmodule

// ===== hw/rtl/tmrr_ctrl.sv =====
// Sequencer of the record ranker: insertion scan and result emission.
// Depends on tmrr_pkg (cmd_t, stat_t, wr_op_t).
`timescale 1ns / 1ps

module tmrr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    input  tmrr_pkg::stat_t stat,
    output tmrr_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_INS_START = 9'b000000010,
        S_INS_RD    = 9'b000000100,
        S_INS_CMP   = 9'b000001000,
        S_INS_TOP   = 9'b000010000,
        S_DONE      = 9'b000100000,
        S_EMIT_RD   = 9'b001000000,
        S_EMIT_LD   = 9'b010000000,
        S_EMIT_WAIT = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_op  = tmrr_pkg::WR_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_rec = 1'b1;
                    state_next   = S_INS_START;
                end
            end
            S_INS_START:
            begin
                if (stat.full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.count_zero)
                begin
                    state_next = S_INS_TOP;
                end
                else
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (stat.above)
                begin
                    cmd.wr_op = tmrr_pkg::WR_SHIFT;
                    if (stat.idx_zero)
                    begin
                        state_next = S_INS_TOP;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = S_INS_RD;
                    end
                end
                else
                begin
                    cmd.wr_op     = tmrr_pkg::WR_NEW_UP;
                    cmd.count_inc = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_INS_TOP:
            begin
                cmd.wr_op     = tmrr_pkg::WR_NEW_TOP;
                cmd.count_inc = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.n_zero)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    if (stat.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_inc = 1'b1;
                        state_next   = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/tmrr_datapath.sv =====
// Datapath of the record ranker: ranked store memory, counters, output register.
// Depends on tmrr_pkg (rec_t, cmd_t, stat_t, ranks_above, weighted).
`timescale 1ns / 1ps

module tmrr_datapath #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmrr_pkg::cmd_t                cmd,
    output tmrr_pkg::stat_t               stat,
    input  logic                          cfg_we,
    input  logic [tmrr_pkg::TOP_W-1:0]    cfg_wdata,
    input  tmrr_pkg::rec_t                in_rec,
    input  logic                          in_last,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [tmrr_pkg::TAG_W-1:0]    out_tag,
    output logic [tmrr_pkg::TENTH_W-1:0]  score_tenths,
    output logic                          records_dropped,
    output logic                          last_result
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int NW = (CW > tmrr_pkg::TOP_W) ? CW : tmrr_pkg::TOP_W;

    tmrr_pkg::rec_t store_reg [MAX_RECORDS];
    tmrr_pkg::rec_t rd_data_reg;
    tmrr_pkg::rec_t rec_reg;
    logic           last_reg;

    logic [CW-1:0]             count_reg;
    logic                      ovf_reg;
    logic [AW-1:0]             idx_reg;
    logic [CW-1:0]             emit_k_reg;
    logic [CW-1:0]             emit_n_reg;
    logic [tmrr_pkg::TOP_W-1:0] top_count_reg;

    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    tmrr_pkg::rec_t             wr_data;
    logic                       wr_en;
    logic [tmrr_pkg::TOP_W-1:0] lim;
    logic [NW-1:0]              n_wide;
    logic [CW-1:0]              n_comb;

    // results to give: min(top_count, 64, stored count)
    assign lim    = (top_count_reg > tmrr_pkg::RESULT_LIMIT) ? tmrr_pkg::RESULT_LIMIT
                                                             : top_count_reg;
    assign n_wide = (NW'(lim) < NW'(count_reg)) ? NW'(lim) : NW'(count_reg);
    assign n_comb = CW'(n_wide);

    assign rd_addr = cmd.rd_emit ? emit_k_reg[AW-1:0] : idx_reg;

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg + AW'(1);
        wr_data = rec_reg;
        unique case (cmd.wr_op)
            tmrr_pkg::WR_SHIFT:   wr_data = rd_data_reg;
            tmrr_pkg::WR_NEW_UP:  wr_data = rec_reg;
            tmrr_pkg::WR_NEW_TOP: wr_addr = '0;
            default:              wr_en   = 1'b0;
        endcase
    end

    // single-port style store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_reg[wr_addr] <= wr_data;
        rd_data_reg <= store_reg[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_rec)
        begin
            rec_reg  <= in_rec;
            last_reg <= in_last;
        end
        if (cmd.idx_init)
            idx_reg <= AW'(count_reg - CW'(1));
        else if (cmd.idx_dec)
            idx_reg <= idx_reg - AW'(1);
        if (cmd.emit_init)
            emit_n_reg <= n_comb;
        if (cmd.out_load)
        begin
            out_tag         <= rd_data_reg.tag;
            score_tenths    <= tmrr_pkg::weighted(rd_data_reg);
            records_dropped <= ovf_reg;
            last_result     <= stat.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            emit_k_reg    <= '0;
            top_count_reg <= '0;
            out_valid     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                top_count_reg <= cfg_wdata;
            if (cmd.clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.count_inc)
                    count_reg <= count_reg + CW'(1);
                if (cmd.set_ovf)
                    ovf_reg <= 1'b1;
            end
            if (cmd.emit_init)
                emit_k_reg <= '0;
            else if (cmd.emit_inc)
                emit_k_reg <= emit_k_reg + CW'(1);
            if (cmd.out_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    assign stat.full       = (count_reg == CW'(MAX_RECORDS));
    assign stat.count_zero = (count_reg == '0);
    assign stat.above      = tmrr_pkg::ranks_above(rec_reg, rd_data_reg);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.last       = last_reg;
    assign stat.n_zero     = (n_comb == '0);
    assign stat.emit_last  = ((emit_k_reg + CW'(1)) == emit_n_reg);

endmodule

// ===== test/top_m_record_ranker_tb.sv =====
// Self-checking testbench for top_m_record_ranker: streams applicant records, ranks them
// in a scoreboard class and checks every shortlist entry the block emits.
// Depends on tmrr_pkg (record type) and the top_m_record_ranker RTL.
`timescale 1ns / 1ps

module top_m_record_ranker_tb;

    localparam int STORE_DEPTH        = 64;    // matches the DUT default MAX_RECORDS
    localparam int SHORTLIST_CAP      = 64;    // top_count saturates here
    localparam int IDLE_SETTLE_CYCLES = 200;   // covers the slowest insertion scan
    localparam int LONG_HOLD_CYCLES   = 600;
    localparam int RANDOM_ITEMS       = 180;
    localparam int BIG_SET_SIZE       = 67;    // overfills the store by three

    // one emitted shortlist entry as the block should present it
    typedef struct packed {
        logic [15:0] tag;
        logic [13:0] tenths;
        logic        dropped;
        logic        closing;
    } shortlist_entry_t;

    // Scoreboard: holds its own ranked copy of the store plus the top_count
    // setting, and queues the shortlist expected on each closing request.
    class shortlist_board;
        tmrr_pkg::rec_t   ranked [STORE_DEPTH];
        int               held;
        bit               any_dropped;
        logic [6:0]       top_count;
        shortlist_entry_t expected_entries [$];
        int unsigned      mismatches;
        int unsigned      entries_checked;
        int unsigned      records_lost;

        function new();
            held            = 0;
            any_dropped     = 0;
            top_count       = '0;
            mismatches      = 0;
            entries_checked = 0;
            records_lost    = 0;
        endfunction

        function logic [13:0] tenths_of(tmrr_pkg::rec_t r);
            logic [13:0] w;
            logic [13:0] i;
            w = 14'(r.written);
            i = 14'(r.interview);
            return (w << 3) + (i << 1);
        endfunction

        // score, then written, then date: one wide unsigned key, larger ranks higher
        function logic [44:0] rank_key(tmrr_pkg::rec_t r);
            return {tenths_of(r), r.written, r.date};
        endfunction

        function void set_top(logic [6:0] value);
            top_count = value;
        endfunction

        function void note_applicant(tmrr_pkg::rec_t r, bit last);
            int pos;
            int n;
            shortlist_entry_t e;
            if (held == STORE_DEPTH)
            begin
                any_dropped = 1'b1;
                records_lost++;
            end
            else
            begin
                // first entry it strictly beats; equal keys stay behind older ones
                pos = held;
                for (int k = 0; k < held; k++)
                    if (pos == held && rank_key(r) > rank_key(ranked[k]))
                        pos = k;
                for (int k = held; k > pos; k--)
                    ranked[k] = ranked[k - 1];
                ranked[pos] = r;
                held++;
            end
            if (last)
            begin
                n = (int'(top_count) > SHORTLIST_CAP) ? SHORTLIST_CAP : int'(top_count);
                if (n > held)
                    n = held;
                for (int k = 0; k < n; k++)
                begin
                    e.tag     = ranked[k].tag;
                    e.tenths  = tenths_of(ranked[k]);
                    e.dropped = any_dropped;
                    e.closing = (k == n - 1);
                    expected_entries.push_back(e);
                end
                held        = 0;
                any_dropped = 1'b0;
            end
        endfunction

        function void check_entry(logic [15:0] tag, logic [13:0] tenths,
                                  logic dropped, logic closing);
            shortlist_entry_t e;
            entries_checked++;
            if (expected_entries.size() == 0)
            begin
                $error("unexpected result: out_tag %0d with nothing pending", tag);
                mismatches++;
                return;
            end
            e = expected_entries.pop_front();
            if (tag !== e.tag)
            begin
                $error("out_tag: expected %0d, got %0d", e.tag, tag);
                mismatches++;
            end
            if (tenths !== e.tenths)
            begin
                $error("score_tenths: expected %0d, got %0d", e.tenths, tenths);
                mismatches++;
            end
            if (dropped !== e.dropped)
            begin
                $error("records_dropped: expected %0d, got %0d", e.dropped, dropped);
                mismatches++;
            end
            if (closing !== e.closing)
            begin
                $error("last_result: expected %0d, got %0d", e.closing, closing);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_entries.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] record_tag;
    logic [9:0]  written_score;
    logic [9:0]  panel_score;
    logic [11:0] year_born;
    logic [3:0]  month_born;
    logic [4:0]  birth_day;
    logic        last_record;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_tag;
    logic [13:0] score_tenths;
    logic        records_dropped;
    logic        last_result;

    shortlist_board board = new();

    int             send_idle_pct;     // chance in 100, per draw, that the sender holds in_valid low
    int             recv_idle_pct;     // chance in 100 that out_ready is low
    bit             long_hold_req;     // asks the receiver for one long stall
    int             records_accepted;
    int             sets_ranked;
    tmrr_pkg::rec_t prev_applicant;    // seed for related (tied) random records

    top_m_record_ranker dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .record_tag      (record_tag),
        .written_score   (written_score),
        .panel_score     (panel_score),
        .year_born       (year_born),
        .month_born      (month_born),
        .birth_day       (birth_day),
        .last_record     (last_record),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_tag         (out_tag),
        .score_tenths    (score_tenths),
        .records_dropped (records_dropped),
        .last_result     (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Everything is observed at the rising edge, before the DUT's own
    // updates land: config writes, accepted requests, accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.set_top(cfg_wdata);
            if (in_valid && in_ready)
            begin
                board.note_applicant({record_tag, written_score, panel_score,
                                      year_born, month_born, birth_day}, last_record);
                records_accepted++;
                if (last_record)
                    sets_ranked++;
            end
            if (out_valid && out_ready)
                board.check_entry(out_tag, score_tenths, records_dropped, last_result);
        end
    end

    // Receiver: random ready each falling edge; one long stall on request,
    // counted here so the sender keeps offering while the block backs up.
    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic tmrr_pkg::rec_t applicant(input logic [15:0] tag, input int w,
                                                 input int i, input int y, input int m,
                                                 input int d);
        tmrr_pkg::rec_t r;
        r.tag       = tag;
        r.written   = 10'(w);
        r.interview = 10'(i);
        r.date      = {y[11:0], m[3:0], d[4:0]};
        return r;
    endfunction

    // Mostly records related to the previous one, so that score ties,
    // written-score ties, date ties and exact duplicates come up often.
    function automatic tmrr_pkg::rec_t random_applicant(input tmrr_pkg::rec_t prev);
        tmrr_pkg::rec_t r;
        int             step;
        r     = prev;
        r.tag = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(9)) inside
            [0:2]:
            begin
                // anything the fields hold, odd months and days included
                r.written   = 10'($urandom_range(1023));
                r.interview = 10'($urandom_range(1023));
                r.date      = 21'($urandom_range(21'h1FFFFF));
            end
            [3:4]:
            begin
                // same weighted score, different written score
                step = $urandom_range(1, 3);
                if (prev.written + step <= 1023 && prev.interview >= 4 * step)
                begin
                    r.written   = 10'(prev.written + step);
                    r.interview = 10'(prev.interview - 4 * step);
                end
                else if (prev.written >= step && prev.interview + 4 * step <= 1023)
                begin
                    r.written   = 10'(prev.written - step);
                    r.interview = 10'(prev.interview + 4 * step);
                end
                r.date[8:5] = 4'($urandom_range(1, 12));
                r.date[4:0] = 5'($urandom_range(1, 31));
            end
            [5:6]:
            begin
                // same scores, the birth date decides
                r.date[20:9] = 12'(prev.date[20:9] + $urandom_range(0, 1));
                r.date[8:5]  = 4'($urandom_range(1, 12));
                r.date[4:0]  = 5'($urandom_range(1, 31));
            end
            7:
            begin
                // full tie with the previous record: arrival order decides
            end
            default:
            begin
                r.written    = 10'($urandom_range(500, 502));
                r.interview  = 10'($urandom_range(500, 502));
                r.date[20:9] = 12'($urandom_range(1990, 1991));
                r.date[8:5]  = 4'($urandom_range(1, 2));
                r.date[4:0]  = 5'($urandom_range(1, 2));
            end
        endcase
        return r;
    endfunction

    // Offer one request; entered and left just after a falling edge. Valid
    // stays high across back-to-back requests.
    task automatic send_record(input tmrr_pkg::rec_t r, input bit last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid      <= 1'b1;
        record_tag    <= r.tag;
        written_score <= r.written;
        panel_score   <= r.interview;
        year_born     <= r.date[20:9];
        month_born    <= r.date[8:5];
        birth_day     <= r.date[4:0];
        last_record   <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender pauses until the whole shortlist is in, then lets a request
    // that causes no result finish its insertion scan.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_top_count(input logic [6:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_set(input int size);
        tmrr_pkg::rec_t r;
        r = prev_applicant;
        for (int k = 0; k < size; k++)
        begin
            r = random_applicant(r);
            send_record(r, k == size - 1);
        end
        prev_applicant = r;
    endtask

    initial
    begin : stimulus
        int set_size;
        int random_sent;
        int set_idx;
        bit big_done;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        record_tag       = '0;
        written_score    = '0;
        panel_score      = '0;
        year_born        = '0;
        month_born       = '0;
        birth_day        = '0;
        last_record      = 1'b0;
        send_idle_pct    = 32;
        recv_idle_pct    = 76;
        long_hold_req    = 1'b0;
        records_accepted = 0;
        sets_ranked      = 0;
        prev_applicant   = applicant(16'd0, 512, 512, 2000, 6, 15);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: all-ones top_count saturates, and a set smaller than M
        // gives only what it holds. Field extremes, every tie-break, a full
        // tie and out-of-range month/day.
        write_top_count(7'd127);
        send_record(applicant(16'hFFFF, 1023, 1023, 4095, 15, 31), 1'b0);
        send_record(applicant(16'd0, 0, 0, 0, 0, 0), 1'b0);
        send_record(applicant(16'd1, 100, 0, 1990, 1, 1), 1'b0);     // 800 tenths
        send_record(applicant(16'd2, 0, 400, 1990, 1, 1), 1'b0);     // 800, lower written
        send_record(applicant(16'd3, 99, 4, 1990, 1, 1), 1'b0);      // 800, between
        send_record(applicant(16'd4, 50, 50, 2000, 5, 10), 1'b0);
        send_record(applicant(16'd5, 50, 50, 2000, 5, 11), 1'b0);    // later day
        send_record(applicant(16'd6, 50, 50, 2000, 6, 1), 1'b0);     // later month
        send_record(applicant(16'd7, 50, 50, 2001, 1, 1), 1'b0);     // later year
        send_record(applicant(16'd8, 50, 50, 2000, 5, 10), 1'b0);    // full tie with tag 4
        send_record(applicant(16'd9, 50, 50, 2000, 13, 0), 1'b0);    // month 13, day 0
        send_record(applicant(16'd10, 1023, 0, 1980, 12, 31), 1'b1);

        // M of zero: nothing comes out, the store must still clear
        write_top_count(7'd0);
        send_record(applicant(16'd11, 300, 300, 1970, 2, 2), 1'b0);
        send_record(applicant(16'd12, 1, 1, 1, 1, 1), 1'b1);

        // single-record set, then M smaller than the set
        write_top_count(7'd1);
        send_record(applicant(16'd13, 512, 511, 2048, 8, 16), 1'b1);
        send_record(applicant(16'd14, 10, 20, 1999, 3, 3), 1'b0);
        send_record(applicant(16'd15, 700, 2, 1960, 7, 7), 1'b0);
        send_record(applicant(16'd16, 5, 5, 2020, 1, 1), 1'b1);

        // Random sets. The first one starts under a long receiver stall, and
        // the next set follows without a pause, so in_ready must hold off.
        // Idling: receiver-heavy third, sender-heavy third, then none. The
        // oversized set opens the last third to overflow the store.
        write_top_count(7'd64);
        long_hold_req = 1'b1;
        random_sent   = 0;
        set_idx       = 0;
        big_done      = 1'b0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 76;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (!big_done && random_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                write_top_count(7'd64);
                set_size = BIG_SET_SIZE;
                big_done = 1'b1;
            end
            else
            begin
                if (set_idx >= 2 && $urandom_range(2) == 0)
                begin
                    case ($urandom_range(5))
                        0:       write_top_count(7'd0);
                        1:       write_top_count(7'd1);
                        2:       write_top_count(7'd64);
                        3:       write_top_count(7'd127);
                        4:       write_top_count(7'($urandom_range(2, 10)));
                        default: write_top_count(7'($urandom_range(127)));
                    endcase
                end
                set_size = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 10);
            end
            send_random_set(set_size);
            random_sent += set_size;
            set_idx++;
        end

        drain_results();
        $display("Ranked %0d records in %0d sets, %0d dropped on a full store.",
                 records_accepted, sets_ranked, board.records_lost);
        $display("Checked %0d shortlist entries across M settings 0, 1, 64, 127 and random.",
                 board.entries_checked);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout with %0d shortlist entries still pending", board.outstanding());
        $display("Regression FAIL");
        $finish;
    end

endmodule
